FILE: sv/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared sizes, cell operation codes and the cell control bundle of the
// string table packer.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int MAX_TOKEN   = 64;

  localparam int SYM_W   = 8;
  localparam int START_W = 12;
  localparam int TAB_AW  = $clog2(TABLE_DEPTH);
  localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TOK_IW  = $clog2(MAX_TOKEN);
  localparam int LEN_W   = $clog2(MAX_TOKEN + 1);

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_LOAD,   // capture token symbol at the selected cell, clear match bit
    CELL_SCAN,   // advance the match bit with one table symbol
    CELL_MASK,   // keep only match bits shorter than the token
    CELL_SEEK,   // move match bits one cell up
    CELL_SHIFT   // move token symbols one cell down
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [SYM_W-1:0]      sym;
    logic                  wr_en;
    logic [TOK_IW-1:0]     wr_idx;
    logic [LEN_W-1:0]      len;
  } cell_ctrl_t;

endpackage

FILE: sv/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/stp_cell.sv
// ----------------------------------------------------------------------------
// stp_cell
// One token position: holds a token symbol and the match bit for the prefix
// ending here. Match bits move up the chain, token symbols move down.
// ----------------------------------------------------------------------------
module stp_cell import stp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TOK_IW-1:0] idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              d_prev_i,
  input  logic [SYM_W-1:0]  tok_next_i,
  output logic              d_o,
  output logic [SYM_W-1:0]  tok_o,
  output logic              hit_o
);

  logic             d_q, d_d;
  logic [SYM_W-1:0] tok_q, tok_d;
  logic [LEN_W:0]   idx_w;
  logic [LEN_W:0]   len_w;

  assign idx_w = (LEN_W + 1)'(idx_i);
  assign len_w = {1'b0, ctrl_i.len};

  // full-length prefix match ends at this cell
  assign hit_o = d_q && ((idx_w + (LEN_W + 1)'(1)) == len_w);

  always_comb begin
    d_d   = d_q;
    tok_d = tok_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        d_d = 1'b0;
        if (ctrl_i.wr_en && (ctrl_i.wr_idx == idx_i)) begin
          tok_d = ctrl_i.sym;
        end
      end
      CELL_SCAN:  d_d   = d_prev_i && (ctrl_i.sym == tok_q);
      CELL_MASK:  d_d   = d_q && ((idx_w + (LEN_W + 1)'(2)) <= len_w);
      CELL_SEEK:  d_d   = d_prev_i;
      CELL_SHIFT: tok_d = tok_next_i;
      default: begin
        d_d   = d_q;
        tok_d = tok_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= 1'b0;
    end else begin
      d_q <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign d_o   = d_q;
  assign tok_o = tok_q;

endmodule

FILE: sv/string_table_packer_unit.sv
// ----------------------------------------------------------------------------
// string_table_packer_unit
// Packs tokens into a shared symbol table, reusing full copies and
// overlapping the table tail with the token prefix.
// ----------------------------------------------------------------------------
// Input channel: one symbol per transfer, last_symbol_i marks the end of a
// token. Symbols past MAX_TOKEN are dropped. Ordinary symbols are not stalled.
// After the last symbol in_stall_o stays high while the token is placed:
//   scan   : one table read per cycle through the RAM port over the used
//            entries; stops early when a full copy shows up
//   seek   : drop match bits as long as the token, then walk match bits up the cell chain
//   check  : compare the token end against TABLE_DEPTH for overflow
//   append : one RAM write per cycle for symbols past the overlap
//            (skipped on a full copy or overflow)
//   result : moved into the output register
// Output channel: one result per token. The result register holds while
// out_stall_i is high; symbols of the next token are still taken and its
// search runs, then it waits in the done state, input stalled, until the
// previous result has left.
// Reset empties the table and token buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
module string_table_packer_unit import stp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic               last_symbol_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [START_W-1:0] start_index_o,
  output logic               reused_o,
  output logic               overflow_o,
  output logic [USED_W-1:0]  used_count_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_MASK,
    S_SEEK,
    S_CHECK,
    S_APPEND,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   tok_len_q, tok_len_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [USED_W-1:0]  addr_q, addr_d;
  logic               v1_q, v1_d;
  logic               v2_q, v2_d;
  logic [USED_W-1:0]  applied_q, applied_d;
  logic [TOK_IW-1:0]  step_q, step_d;
  logic [LEN_W-1:0]   k_q, k_d;
  logic [LEN_W-1:0]   app_q, app_d;
  logic [USED_W-1:0]  found_q, found_d;
  logic [START_W-1:0] res_start_q, res_start_d;
  logic               res_reused_q, res_reused_d;
  logic               res_ovf_q, res_ovf_d;
  logic [USED_W-1:0]  res_used_q, res_used_d;
  logic               out_valid_q, out_valid_d;
  logic [START_W-1:0] out_start_q, out_start_d;
  logic               out_reused_q, out_reused_d;
  logic               out_ovf_q, out_ovf_d;
  logic [USED_W-1:0]  out_used_q, out_used_d;

  cell_ctrl_t         ctrl;
  logic               d_w   [MAX_TOKEN];
  logic [SYM_W-1:0]   tok_w [MAX_TOKEN];
  logic [MAX_TOKEN-1:0] hit_w;
  logic               hit_any;

  logic               ram_re, ram_we;
  logic [TAB_AW-1:0]  ram_waddr;
  logic [SYM_W-1:0]   ram_rdata;
  logic               in_xfer;
  logic [USED_W-1:0]  found_w;
  logic [USED_W:0]    end_w;
  logic [USED_W-1:0]  wr_pos;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign hit_any    = |hit_w;
  assign found_w    = used_q - USED_W'(k_q);
  assign end_w      = {1'b0, found_w} + (USED_W + 1)'(len_q);
  assign wr_pos     = found_q + USED_W'(app_q);
  assign ram_waddr  = wr_pos[TAB_AW-1:0];

  stp_ram #(
    .Width (SYM_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tok_w[0]),
    .re_i    (ram_re),
    .raddr_i (addr_q[TAB_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  for (genvar g = 0; g < MAX_TOKEN; g++) begin : g_cell
    logic             d_prev;
    logic [SYM_W-1:0] tok_next;

    if (g == 0) begin : g_first
      // the empty prefix always matches while scanning
      assign d_prev = (ctrl.op == CELL_SCAN);
    end else begin : g_mid
      assign d_prev = d_w[g-1];
    end

    if (g == MAX_TOKEN - 1) begin : g_last
      assign tok_next = '0;
    end else begin : g_low
      assign tok_next = tok_w[g+1];
    end

    stp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (TOK_IW'(g)),
      .ctrl_i     (ctrl),
      .d_prev_i   (d_prev),
      .tok_next_i (tok_next),
      .d_o        (d_w[g]),
      .tok_o      (tok_w[g]),
      .hit_o      (hit_w[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    tok_len_d    = tok_len_q;
    len_d        = len_q;
    used_d       = used_q;
    addr_d       = addr_q;
    v1_d         = 1'b0;
    v2_d         = 1'b0;
    applied_d    = applied_q;
    step_d       = step_q;
    k_d          = k_q;
    app_d        = app_q;
    found_d      = found_q;
    res_start_d  = res_start_q;
    res_reused_d = res_reused_q;
    res_ovf_d    = res_ovf_q;
    res_used_d   = res_used_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_start_d  = out_start_q;
    out_reused_d = out_reused_q;
    out_ovf_d    = out_ovf_q;
    out_used_d   = out_used_q;

    ctrl.op      = CELL_IDLE;
    ctrl.sym     = (state_q == S_SCAN) ? ram_rdata : symbol_i;
    ctrl.wr_en   = tok_len_q < LEN_W'(MAX_TOKEN);
    ctrl.wr_idx  = tok_len_q[TOK_IW-1:0];
    ctrl.len     = len_q;
    ram_re       = 1'b0;
    ram_we       = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          ctrl.op = CELL_LOAD;
          if (tok_len_q < LEN_W'(MAX_TOKEN)) begin
            tok_len_d = tok_len_q + LEN_W'(1);
          end
          if (last_symbol_i) begin
            len_d     = (tok_len_q < LEN_W'(MAX_TOKEN)) ? tok_len_q + LEN_W'(1)
                                                        : tok_len_q;
            tok_len_d = '0;
            addr_d    = '0;
            applied_d = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read, then advance the chain, then look at the registered hits
        ram_re = addr_q < used_q;
        if (ram_re) begin
          addr_d = addr_q + USED_W'(1);
        end
        v1_d = ram_re;
        v2_d = v1_q;
        if (v1_q) begin
          ctrl.op   = CELL_SCAN;
          applied_d = applied_q + USED_W'(1);
        end
        if (v2_q && hit_any) begin
          res_start_d  = START_W'(applied_q - USED_W'(len_q));
          res_reused_d = 1'b1;
          res_ovf_d    = 1'b0;
          res_used_d   = used_q;
          state_d      = S_DONE;
        end else if (!ram_re && !v1_q && !v2_q) begin
          state_d = S_MASK;
        end
      end
      S_MASK: begin
        ctrl.op = CELL_MASK;
        step_d  = '0;
        state_d = S_SEEK;
      end
      S_SEEK: begin
        // top cell shows match bits from the longest overlap downward
        if (d_w[MAX_TOKEN-1]) begin
          k_d     = LEN_W'(MAX_TOKEN) - LEN_W'(step_q);
          state_d = S_CHECK;
        end else if (step_q == TOK_IW'(MAX_TOKEN - 1)) begin
          k_d     = '0;
          state_d = S_CHECK;
        end else begin
          ctrl.op = CELL_SEEK;
          step_d  = step_q + TOK_IW'(1);
        end
      end
      S_CHECK: begin
        found_d = found_w;
        app_d   = '0;
        if (end_w > (USED_W + 1)'(TABLE_DEPTH)) begin
          res_start_d  = '0;
          res_reused_d = 1'b0;
          res_ovf_d    = 1'b1;
          res_used_d   = used_q;
          state_d      = S_DONE;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        ctrl.op = CELL_SHIFT;
        // overlapping symbols are already in the table
        ram_we  = app_q >= k_q;
        if (app_q == len_q - LEN_W'(1)) begin
          used_d       = found_q + USED_W'(len_q);
          res_start_d  = found_q[START_W-1:0];
          res_reused_d = 1'b0;
          res_ovf_d    = 1'b0;
          res_used_d   = found_q + USED_W'(len_q);
          state_d      = S_DONE;
        end else begin
          app_d = app_q + LEN_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_start_d  = res_start_q;
          out_reused_d = res_reused_q;
          out_ovf_d    = res_ovf_q;
          out_used_d   = res_used_q;
          state_d      = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      tok_len_q    <= '0;
      len_q        <= '0;
      used_q       <= '0;
      addr_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      applied_q    <= '0;
      step_q       <= '0;
      k_q          <= '0;
      app_q        <= '0;
      found_q      <= '0;
      res_start_q  <= '0;
      res_reused_q <= 1'b0;
      res_ovf_q    <= 1'b0;
      res_used_q   <= '0;
      out_valid_q  <= 1'b0;
      out_start_q  <= '0;
      out_reused_q <= 1'b0;
      out_ovf_q    <= 1'b0;
      out_used_q   <= '0;
    end else begin
      state_q      <= state_d;
      tok_len_q    <= tok_len_d;
      len_q        <= len_d;
      used_q       <= used_d;
      addr_q       <= addr_d;
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      applied_q    <= applied_d;
      step_q       <= step_d;
      k_q          <= k_d;
      app_q        <= app_d;
      found_q      <= found_d;
      res_start_q  <= res_start_d;
      res_reused_q <= res_reused_d;
      res_ovf_q    <= res_ovf_d;
      res_used_q   <= res_used_d;
      out_valid_q  <= out_valid_d;
      out_start_q  <= out_start_d;
      out_reused_q <= out_reused_d;
      out_ovf_q    <= out_ovf_d;
      out_used_q   <= out_used_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign start_index_o = out_start_q;
  assign reused_o      = out_reused_q;
  assign overflow_o    = out_ovf_q;
  assign used_count_o  = out_used_q;

endmodule
